[sv/sphere_boundary_penalty_force_assert.svh]
// Assertion macros shared by the sphere boundary penalty force RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef SPHERE_BOUNDARY_PENALTY_FORCE_ASSERT_SVH
`define SPHERE_BOUNDARY_PENALTY_FORCE_ASSERT_SVH

// Same-cycle implication.
`define SBPF_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sbpf assertion failed");

// Next-cycle implication.
`define SBPF_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sbpf assertion failed");

`endif

[sv/sbpf_pkg.sv]
// Shared constants, register map and width helpers for the sphere boundary
// penalty force block. No dependencies.
package sbpf_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CENTRE_BITS    = 32;
    localparam int RADIUS_BITS    = 31;
    localparam int INV_BITS       = 32;
    localparam int OUT_BITS       = 32;
    localparam int CFG_ADDR_BITS  = 5;
    localparam int CFG_DATA_BITS  = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 31'd65536;
    localparam logic [INV_BITS-1:0]    INV_RESET    = 32'd65536;

    // clamp magnitudes: positive force, negative force
    localparam logic [OUT_BITS-1:0] SAT_POS_MAG = 32'h7FFF_FFFF;
    localparam logic [OUT_BITS-1:0] SAT_NEG_MAG = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_CENTRE_X    = 3'd0,
        REG_CENTRE_Y    = 3'd1,
        REG_CENTRE_Z    = 3'd2,
        REG_RADIUS      = 3'd3,
        REG_INV_STEP_SQ = 3'd4
    } sbpf_reg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sbpf_qstat_t;

    // magnitude of a coordinate difference
    function automatic int mag_w(int cb);
        return ((cb > CENTRE_BITS) ? cb : CENTRE_BITS) + 1;
    endfunction

    // sum of three squares
    function automatic int sum_w(int cb);
        return 2 * mag_w(cb) + 2;
    endfunction

    // integer square root of the sum
    function automatic int root_w(int cb);
        return mag_w(cb) + 1;
    endfunction

    // mag * inv_step_sq * over
    function automatic int prod_w(int cb);
        return mag_w(cb) + INV_BITS + root_w(cb);
    endfunction

    // dist << FRAC_BITS
    function automatic int den_w(int cb, int fb);
        return root_w(cb) + fb;
    endfunction

    // divider remainder
    function automatic int rem_w(int cb, int fb);
        int p;
        int d;
        p = prod_w(cb);
        d = den_w(cb, fb) + OUT_BITS;
        return (p > d) ? p : d;
    endfunction

endpackage

[sv/sbpf_front.sv]
// Front end: accepts positions, forms centre deltas, squares them and
// classifies inside/outside. Depends on sbpf_pkg.
module sbpf_front
    import sbpf_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [3*CB-1:0]          in_pos,
    input  logic [3*CENTRE_BITS-1:0] centre,
    input  logic [RADIUS_BITS-1:0]   radius,
    input  logic                     q_full,
    output logic                     item_valid,
    output logic [3*mag_w(CB)-1:0]   item_mag,
    output logic [2:0]               item_pos,
    output logic [sum_w(CB)-1:0]     item_sum,
    output logic                     item_outside
);
    localparam int MW = mag_w(CB);
    localparam int SW = sum_w(CB);
    localparam int R2W = 2 * RADIUS_BITS;

    logic [3:0] vld_reg;
    logic       en;

    logic signed [MW-1:0] d_c   [3];
    logic        [MW-1:0] mag_c [3];
    logic        [2:0]    pos_c;

    logic [MW-1:0]   mag1_reg [3];
    logic [2:0]      pos1_reg;
    logic [2*MW-1:0] sq2_reg  [3];
    logic [MW-1:0]   mag2_reg [3];
    logic [2:0]      pos2_reg;
    logic [R2W-1:0]  r2_2_reg;
    logic [SW-1:0]   s3_reg;
    logic [MW-1:0]   mag3_reg [3];
    logic [2:0]      pos3_reg;
    logic [R2W-1:0]  r2_3_reg;
    logic [SW-1:0]   s4_reg;
    logic [MW-1:0]   mag4_reg [3];
    logic [2:0]      pos4_reg;
    logic            out4_reg;

    assign en       = !vld_reg[3] || !q_full;
    assign in_ready = en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_c[i] = MW'($signed(in_pos[i*CB +: CB]))
                   - MW'($signed(centre[i*CENTRE_BITS +: CENTRE_BITS]));
            mag_c[i] = d_c[i][MW-1] ? (~d_c[i] + 1'b1) : d_c[i];
            pos_c[i] = !d_c[i][MW-1] && (d_c[i] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= mag_c[i];
                sq2_reg[i]  <= mag1_reg[i] * mag1_reg[i];
                mag2_reg[i] <= mag1_reg[i];
                mag3_reg[i] <= mag2_reg[i];
                mag4_reg[i] <= mag3_reg[i];
            end
            pos1_reg <= pos_c;
            pos2_reg <= pos1_reg;
            r2_2_reg <= radius * radius;
            s3_reg   <= SW'(sq2_reg[0]) + SW'(sq2_reg[1]) + SW'(sq2_reg[2]);
            pos3_reg <= pos2_reg;
            r2_3_reg <= r2_2_reg;
            s4_reg   <= s3_reg;
            pos4_reg <= pos3_reg;
            out4_reg <= s3_reg > SW'(r2_3_reg);
        end
    end

    assign item_valid   = vld_reg[3];
    assign item_mag     = {mag4_reg[2], mag4_reg[1], mag4_reg[0]};
    assign item_pos     = pos4_reg;
    assign item_sum     = s4_reg;
    assign item_outside = out4_reg;

endmodule

[sv/sbpf_queue.sv]
// Short FIFO between the front end and the force pipeline.
// Depends on sbpf_pkg and the assertion macro header.
`include "sphere_boundary_penalty_force_assert.svh"

module sbpf_queue
    import sbpf_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output sbpf_qstat_t  status
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata        = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

    `SBPF_ASSERT_NOW(a_no_overflow, push, !status.full || pop)
    `SBPF_ASSERT_NOW(a_no_underflow, pop, !status.empty)
    `SBPF_ASSERT_NEXT(a_push_lands, push && !pop, !status.empty)
    `SBPF_ASSERT_NOW(a_count_range, 1'b1, count_reg <= CW'(DEPTH))

endmodule

[sv/sbpf_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with a
// sideband carried alongside. Depends on sbpf_pkg.
module sbpf_isqrt
    import sbpf_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF,
    parameter int TW = 1
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [sum_w(CB)-1:0]  s,
    input  logic [TW-1:0]         side_in,
    output logic [root_w(CB)-1:0] root,
    output logic [TW-1:0]         side_out
);
    localparam int SW = sum_w(CB);
    localparam int RW = root_w(CB);

    logic [RW-1:0] res_reg  [RW];
    logic [SW-1:0] rem_reg  [RW];
    logic [TW-1:0] side_reg [RW];

    for (genvar j = 0; j < RW; j++)
    begin : g_stage
        localparam int B = RW - 1 - j;
        logic [RW-1:0] res_in;
        logic [SW-1:0] rem_in;
        logic [SW-1:0] trial;
        logic [TW-1:0] side_i;

        if (j == 0)
        begin : g_first
            assign res_in = '0;
            assign rem_in = s;
            assign side_i = side_in;
        end
        else
        begin : g_next
            assign res_in = res_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign side_i = side_reg[j-1];
        end

        // (res + 2^B)^2 - res^2; remainder holds s - res^2
        assign trial = (SW'(res_in) << (B + 1)) | (SW'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial <= rem_in)
                begin
                    rem_reg[j] <= rem_in - trial;
                    res_reg[j] <= res_in | (RW'(1) << B);
                end
                else
                begin
                    rem_reg[j] <= rem_in;
                    res_reg[j] <= res_in;
                end
                side_reg[j] <= side_i;
            end
        end
    end

    assign root     = res_reg[RW-1];
    assign side_out = side_reg[RW-1];

endmodule

[sv/sbpf_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, 32-bit quotient.
// Depends on sbpf_pkg.
module sbpf_divider
    import sbpf_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF,
    parameter int FB = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [rem_w(CB, FB)-1:0] num,
    input  logic [den_w(CB, FB)-1:0] den,
    input  logic                     sat_in,
    output logic [OUT_BITS-1:0]      quot,
    output logic                     sat_out
);
    localparam int LW  = rem_w(CB, FB);
    localparam int DVW = den_w(CB, FB);

    logic [LW-1:0]       rem_reg [OUT_BITS];
    logic [DVW-1:0]      den_reg [OUT_BITS];
    logic [OUT_BITS-1:0] quo_reg [OUT_BITS];
    logic                sat_reg [OUT_BITS];

    for (genvar j = 0; j < OUT_BITS; j++)
    begin : g_stage
        localparam int K = OUT_BITS - 1 - j;
        logic [LW-1:0]       rem_in;
        logic [LW-1:0]       trial;
        logic [DVW-1:0]      den_in;
        logic [OUT_BITS-1:0] quo_in;
        logic                sat_i;

        if (j == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
            assign sat_i  = sat_in;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign sat_i  = sat_reg[j-1];
        end

        assign trial = LW'(den_in) << K;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[j] <= rem_in - trial;
                    quo_reg[j] <= quo_in | (OUT_BITS'(1) << K);
                end
                else
                begin
                    rem_reg[j] <= rem_in;
                    quo_reg[j] <= quo_in;
                end
                den_reg[j] <= den_in;
                sat_reg[j] <= sat_i;
            end
        end
    end

    assign quot    = quo_reg[OUT_BITS-1];
    assign sat_out = sat_reg[OUT_BITS-1];

endmodule

[sv/sbpf_back.sv]
// Back end: square root, force products, saturation check, three dividers
// and the output register. Depends on sbpf_pkg, sbpf_isqrt, sbpf_divider.
module sbpf_back
    import sbpf_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF,
    parameter int FB = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_pop,
    input  logic [3*mag_w(CB)-1:0] in_mag,
    input  logic [2:0]             in_pos,
    input  logic [sum_w(CB)-1:0]   in_sum,
    input  logic                   in_outside,
    input  logic [RADIUS_BITS-1:0] radius,
    input  logic [INV_BITS-1:0]    inv_step_sq,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3*OUT_BITS-1:0]  out_force,
    output logic                   out_outside,
    output logic                   out_saturated
);
    localparam int MW  = mag_w(CB);
    localparam int RW  = root_w(CB);
    localparam int AW  = MW + INV_BITS;
    localparam int PLW = INV_BITS + RW;
    localparam int PHW = MW + RW;
    localparam int PW  = prod_w(CB);
    localparam int DVW = den_w(CB, FB);
    localparam int LW  = rem_w(CB, FB);
    localparam int TGW = 4;
    localparam int SDW = TGW + 3 * MW;
    localparam int NS  = RW + 4 + OUT_BITS + 1;

    logic [NS-1:0] vld_reg;
    logic          en;

    logic [RW-1:0]  root;
    logic [SDW-1:0] side_s;

    logic [RW-1:0]  dist1_reg;
    logic [RW-1:0]  over1_reg;
    logic [AW-1:0]  a1_reg  [3];
    logic [TGW-1:0] tag1_reg;
    logic [PLW-1:0] pl2_reg [3];
    logic [PHW-1:0] ph2_reg [3];
    logic [RW-1:0]  dist2_reg;
    logic [TGW-1:0] tag2_reg;
    logic [PW-1:0]  p3_reg  [3];
    logic [LW-1:0]  thr3_reg[3];
    logic [DVW-1:0] d3_reg;
    logic [TGW-1:0] tag3_reg;
    logic [LW-1:0]  num4_reg[3];
    logic           sat4_reg[3];
    logic [DVW-1:0] d4_reg;
    logic [TGW-1:0] tag4_reg;
    logic [TGW-1:0] tagd_reg[OUT_BITS];

    logic [DVW-1:0]      d_c;
    logic [OUT_BITS-1:0] quot  [3];
    logic                satd  [3];
    logic [OUT_BITS-1:0] mag_o [3];
    logic [OUT_BITS-1:0] frc_o [3];
    logic [OUT_BITS-1:0] force_reg [3];
    logic                outside_reg;
    logic                saturated_reg;

    // one stall enable for the whole pipeline, released by the output side
    assign en     = !vld_reg[NS-1] || out_ready;
    assign in_pop = en && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    sbpf_isqrt #(
        .CB (CB),
        .TW (SDW)
    ) u_isqrt (
        .clk      (clk),
        .en       (en),
        .s        (in_sum),
        .side_in  ({in_outside, in_pos, in_mag}),
        .root     (root),
        .side_out (side_s)
    );

    assign d_c = DVW'(dist2_reg) << FB;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // products
            dist1_reg <= root;
            over1_reg <= root - RW'(radius);
            tag1_reg  <= side_s[SDW-1 -: TGW];
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i]  <= side_s[i*MW +: MW] * inv_step_sq;
                pl2_reg[i] <= a1_reg[i][INV_BITS-1:0] * over1_reg;
                ph2_reg[i] <= a1_reg[i][AW-1:INV_BITS] * over1_reg;
                p3_reg[i]  <= PW'(pl2_reg[i]) + (PW'(ph2_reg[i]) << INV_BITS);
                // clamp threshold: (limit + 1) * divisor
                thr3_reg[i] <= tag2_reg[i] ? (LW'(d_c) << (OUT_BITS - 1)) + LW'(d_c)
                                           : (LW'(d_c) << (OUT_BITS - 1));
                num4_reg[i] <= LW'(p3_reg[i]);
                sat4_reg[i] <= LW'(p3_reg[i]) >= thr3_reg[i];
            end
            dist2_reg <= dist1_reg;
            tag2_reg  <= tag1_reg;
            d3_reg    <= d_c;
            tag3_reg  <= tag2_reg;
            d4_reg    <= d3_reg;
            tag4_reg  <= tag3_reg;
            tagd_reg[0] <= tag4_reg;
            for (int k = 1; k < OUT_BITS; k++)
            begin
                tagd_reg[k] <= tagd_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        sbpf_divider #(
            .CB (CB),
            .FB (FB)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .num     (num4_reg[i]),
            .den     (d4_reg),
            .sat_in  (sat4_reg[i]),
            .quot    (quot[i]),
            .sat_out (satd[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (satd[i])
            begin
                mag_o[i] = tagd_reg[OUT_BITS-1][i] ? SAT_NEG_MAG : SAT_POS_MAG;
            end
            else
            begin
                mag_o[i] = quot[i];
            end
            // force points back toward the centre
            frc_o[i] = tagd_reg[OUT_BITS-1][i] ? (~mag_o[i] + 1'b1) : mag_o[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                force_reg[i] <= tagd_reg[OUT_BITS-1][3] ? frc_o[i] : '0;
            end
            outside_reg   <= tagd_reg[OUT_BITS-1][3];
            saturated_reg <= tagd_reg[OUT_BITS-1][3] && (satd[0] || satd[1] || satd[2]);
        end
    end

    assign out_valid     = vld_reg[NS-1];
    assign out_force     = {force_reg[2], force_reg[1], force_reg[0]};
    assign out_outside   = outside_reg;
    assign out_saturated = saturated_reg;

endmodule

[sv/sphere_boundary_penalty_force.sv]
// Path from input transaction to result: 4 front stages, queue, one sqrt
//   stage per root bit, 4 product stages, 32 divider stages, output register.
// Throughput: one transaction per cycle while neither m_axis_tready nor a full queue stalls it.
// Reset: rst_n async active low clears valids and queue, loads config reset values.
module sphere_boundary_penalty_force
    import sbpf_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream: positions
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,  // pos_x, pos_y, pos_z
    // master stream: forces
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [3*OUT_BITS-1:0]               m_axis_tdata,  // force_x, force_y, force_z
    output logic [1:0]                          m_axis_tuser,  // outside, saturated
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [CFG_ADDR_BITS-1:0]            paddr,
    input  logic [CFG_DATA_BITS-1:0]            pwdata,
    output logic [CFG_DATA_BITS-1:0]            prdata,
    output logic                                pready
);
    localparam int MW = mag_w(COORD_BITS);
    localparam int SW = sum_w(COORD_BITS);
    localparam int QW = 3 * MW + 3 + SW + 1;

    // Config registers; the user must write them only while the datapath is drained (not
    // enforced by the block), so the pipelines read them directly at whatever stage needs them.
    logic [CENTRE_BITS-1:0] centre_x_reg;
    logic [CENTRE_BITS-1:0] centre_y_reg;
    logic [CENTRE_BITS-1:0] centre_z_reg;
    logic [RADIUS_BITS-1:0] radius_reg;
    logic [INV_BITS-1:0]    inv_step_sq_reg;
    sbpf_reg_t              reg_sel;
    logic                   cfg_wr;

    logic            item_valid;
    logic [3*MW-1:0] item_mag;
    logic [2:0]      item_pos;
    logic [SW-1:0]   item_sum;
    logic            item_outside;
    logic            q_push;
    logic            q_pop;
    logic [QW-1:0]   q_rdata;
    sbpf_qstat_t     q_stat;

    assign pready  = 1'b1;
    assign reg_sel = sbpf_reg_t'(paddr[CFG_ADDR_BITS-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg    <= '0;
            centre_y_reg    <= '0;
            centre_z_reg    <= '0;
            radius_reg      <= RADIUS_RESET;
            inv_step_sq_reg <= INV_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_CENTRE_X:    centre_x_reg    <= pwdata[CENTRE_BITS-1:0];
                REG_CENTRE_Y:    centre_y_reg    <= pwdata[CENTRE_BITS-1:0];
                REG_CENTRE_Z:    centre_z_reg    <= pwdata[CENTRE_BITS-1:0];
                REG_RADIUS:      radius_reg      <= pwdata[RADIUS_BITS-1:0];
                REG_INV_STEP_SQ: inv_step_sq_reg <= pwdata[INV_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_CENTRE_X:    prdata = centre_x_reg;
            REG_CENTRE_Y:    prdata = centre_y_reg;
            REG_CENTRE_Z:    prdata = centre_z_reg;
            REG_RADIUS:      prdata = CFG_DATA_BITS'(radius_reg);
            REG_INV_STEP_SQ: prdata = inv_step_sq_reg;
            default:         prdata = '0;
        endcase
    end

    // Front: deltas, squares, inside/outside classification.
    sbpf_front #(
        .CB (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_pos       (s_axis_tdata[3*COORD_BITS-1:0]),
        .centre       ({centre_z_reg, centre_y_reg, centre_x_reg}),
        .radius       (radius_reg),
        .q_full       (q_stat.full),
        .item_valid   (item_valid),
        .item_mag     (item_mag),
        .item_pos     (item_pos),
        .item_sum     (item_sum),
        .item_outside (item_outside)
    );

    assign q_push = item_valid && !q_stat.full;

    // Queue lets the front keep accepting while the back end is stalled.
    sbpf_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  ({item_outside, item_sum, item_pos, item_mag}),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_stat)
    );

    // Back: sqrt, products, clamp check, dividers, output register.
    sbpf_back #(
        .CB (COORD_BITS),
        .FB (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (!q_stat.empty),
        .in_pop        (q_pop),
        .in_mag        (q_rdata[3*MW-1:0]),
        .in_pos        (q_rdata[3*MW +: 3]),
        .in_sum        (q_rdata[3*MW+3 +: SW]),
        .in_outside    (q_rdata[QW-1]),
        .radius        (radius_reg),
        .inv_step_sq   (inv_step_sq_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_force     (m_axis_tdata),
        .out_outside   (m_axis_tuser[0]),
        .out_saturated (m_axis_tuser[1])
    );

endmodule

[bench/sphere_boundary_penalty_force_test.sv]
// Self-checking bench for sphere_boundary_penalty_force: random and directed positions
// under several sphere settings, checked against an in-bench force predictor.
// Depends on sbpf_pkg and the block RTL only.
`timescale 1ns / 100ps

module sphere_boundary_penalty_force_test;
    import sbpf_pkg::*;

    localparam int LAT       = 75;      // allowance for the input-to-result latency
    localparam int LIMIT     = 400000;  // cycle budget, several times the slowest run
    localparam int LONG_HOLD = 300;     // receiver back-pressure stretch

    // expected result of one position transaction
    typedef struct packed {
        logic [31:0] fz;
        logic [31:0] fy;
        logic [31:0] fx;
        logic        outside;
        logic        sat;
    } force_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // pos_x, pos_y, pos_z
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // force_x, force_y, force_z
    logic [1:0]  m_axis_tuser;   // outside, saturated
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sphere_boundary_penalty_force dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // bench copy of the register file
    logic [31:0] cen_x, cen_y, cen_z, inv_sq;
    logic [30:0] radius;

    logic [95:0] positions_todo[$];   // positions waiting for the driver
    force_t      forces_due[$];       // predicted results in order
    int          fail_cnt;
    int          cycles;
    bit          no_gaps;             // burst stretches: no idling on either side
    bit          long_hold_tgl;       // toggled to request one long receiver hold
    logic        s_took, m_took;      // handshake seen at the last rising edge

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, 9);
    endfunction

    // Penalty force: exact wide arithmetic, truncation toward zero, then clamp.
    function automatic force_t penalty_force(input logic [95:0] pos);
        force_t           r;
        logic [31:0]      cen[3];
        logic signed [33:0] d;
        logic [32:0]      mag[3];
        logic             pos_side[3];
        logic [127:0]     s, c, root_v, over, divisor, q, lim;
        logic [31:0]      m;
        cen[0] = cen_x; cen[1] = cen_y; cen[2] = cen_z;
        r = '0;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            d = $signed({{2{pos[32*i+31]}}, pos[32*i +: 32]})
              - $signed({{2{cen[i][31]}}, cen[i]});
            pos_side[i] = d > 0;
            mag[i] = d < 0 ? 33'(-d) : 33'(d);
            s = s + 128'(mag[i]) * 128'(mag[i]);
        end
        if (s > 128'(radius) * 128'(radius)) begin
            r.outside = 1'b1;
            root_v = '0;
            for (int b = 34; b >= 0; b--) begin
                c = root_v | (128'd1 << b);
                if (c * c <= s) root_v = c;
            end
            over    = root_v - 128'(radius);
            divisor = root_v << 16;
            for (int i = 0; i < 3; i++) begin
                q   = (128'(mag[i]) * 128'(inv_sq) * over) / divisor;
                // a force on the positive side is negative, so it may reach -2^31
                lim = pos_side[i] ? 128'(SAT_NEG_MAG) : 128'(SAT_POS_MAG);
                if (q > lim) begin
                    q     = lim;
                    r.sat = 1'b1;
                end
                m = q[31:0];
                if (pos_side[i]) m = -m;
                case (i)
                    0: r.fx = m;
                    1: r.fy = m;
                    default: r.fz = m;
                endcase
            end
        end
        return r;
    endfunction

    // Sender: one position per handshake, random gap after each launch.
    int gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left      <= 0;
        end
        else if (s_axis_tvalid && !s_took)
        begin
            // hold the transaction until it is taken
        end
        else if (gap_left > 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left      <= gap_left - 1;
        end
        else if (positions_todo.size() > 0)
        begin
            s_axis_tdata  <= positions_todo.pop_front();
            s_axis_tvalid <= 1'b1;
            gap_left      <= draw_wait();
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // Receiver: random stall per result, plus one long hold on request.
    int  stall_left;
    int  hold_left;
    bit  hold_seen;
    always @(negedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            hold_left     <= 0;
            hold_seen     <= 1'b0;
        end
        else if (hold_seen != long_hold_tgl)
        begin
            hold_seen     <= long_hold_tgl;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (m_took)
        begin
            n = draw_wait();
            stall_left    <= (n > 0) ? n - 1 : 0;
            m_axis_tready <= (n == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Monitor: predict on input transactions, compare on output transactions.
    always @(posedge clk or negedge rst_n)
    begin
        force_t e;
        if (!rst_n)
        begin
            s_took <= 1'b0;
            m_took <= 1'b0;
        end
        else
        begin
            s_took <= s_axis_tvalid && s_axis_tready;
            m_took <= m_axis_tvalid && m_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                forces_due.push_back(penalty_force(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (forces_due.size() == 0)
                begin
                    $error("unexpected result transaction");
                    fail_cnt++;
                end
                else
                begin
                    e = forces_due.pop_front();
                    if (m_axis_tdata[31:0] !== e.fx)
                    begin
                        $error("force_x exp %h got %h", e.fx, m_axis_tdata[31:0]);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[63:32] !== e.fy)
                    begin
                        $error("force_y exp %h got %h", e.fy, m_axis_tdata[63:32]);
                        fail_cnt++;
                    end
                    if (m_axis_tdata[95:64] !== e.fz)
                    begin
                        $error("force_z exp %h got %h", e.fz, m_axis_tdata[95:64]);
                        fail_cnt++;
                    end
                    if (m_axis_tuser[0] !== e.outside)
                    begin
                        $error("outside exp %b got %b", e.outside, m_axis_tuser[0]);
                        fail_cnt++;
                    end
                    if (m_axis_tuser[1] !== e.sat)
                    begin
                        $error("saturated exp %b got %b", e.sat, m_axis_tuser[1]);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Register write: setup then access phase; the bench copy follows at the access edge.
    task automatic reg_write(input sbpf_reg_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        case (idx)
            REG_CENTRE_X:    cen_x  = val;
            REG_CENTRE_Y:    cen_y  = val;
            REG_CENTRE_Z:    cen_z  = val;
            REG_RADIUS:      radius = val[30:0];
            REG_INV_STEP_SQ: inv_sq = val;
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Block until every position went in and every result came out.
    task automatic drain();
        while (positions_todo.size() > 0 || s_axis_tvalid || forces_due.size() > 0)
            @(negedge clk);
    endtask

    task automatic load_sphere(input logic [31:0] cx, cy, cz, rad, inv);
        drain();
        repeat (LAT + 6) @(negedge clk);
        reg_write(REG_CENTRE_X, cx);
        reg_write(REG_CENTRE_Y, cy);
        reg_write(REG_CENTRE_Z, cz);
        reg_write(REG_RADIUS, rad);
        reg_write(REG_INV_STEP_SQ, inv);
    endtask

    // Coordinate near the sphere surface on one axis, or on the centre plane.
    function automatic logic [31:0] near_coord(input logic [31:0] c);
        logic [31:0] off;
        if ($urandom_range(0, 9) == 0) return c;
        off = $urandom_range(0, radius + 32'd16);
        return $urandom_range(0, 1) ? c + off : c - off;
    endfunction

    function automatic logic [95:0] random_position();
        if ($urandom_range(0, 9) < 6)
            return {near_coord(cen_z), near_coord(cen_y), near_coord(cen_x)};
        return {$urandom(), $urandom(), $urandom()};
    endfunction

    initial
    begin
        logic [31:0] rad;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        no_gaps  = 1'b0;
        long_hold_tgl = 1'b0;
        fail_cnt = 0;
        cycles   = 0;
        cen_x = '0; cen_y = '0; cen_z = '0;
        radius = RADIUS_RESET;
        inv_sq = INV_RESET;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset settings: unit sphere at the origin.
        positions_todo.push_back('0);                                 // at the centre
        positions_todo.push_back({32'd0, 32'd0, 32'h0001_0000});      // on the sphere
        positions_todo.push_back({32'd0, 32'd1, 32'h0001_0000});      // rounds to radius
        positions_todo.push_back({32'd0, 32'h0003_0000, 32'hFFFE_0000}); // z on the plane
        positions_todo.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        positions_todo.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        positions_todo.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000});
        positions_todo.push_back({32'hFFFF_FFFF, 32'h0000_0001, 32'h0002_0000});

        // Zero radius, largest step factor: most off-centre positions saturate.
        load_sphere('0, '0, '0, 32'h0, 32'hFFFF_FFFF);
        positions_todo.push_back('0);
        positions_todo.push_back({32'd0, 32'd0, 32'd1});
        positions_todo.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        positions_todo.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        positions_todo.push_back({32'h0010_0000, 32'hFFF0_0000, 32'h0000_0000});

        // Extreme centres, largest radius, zero step factor; an unmapped address is ignored.
        // The radius write sets bit 31 too, which the block must drop.
        load_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
        reg_write(sbpf_reg_t'(3'd5), 32'hDEAD_BEEF);
        reg_write(sbpf_reg_t'(3'd7), 32'h1234_5678);
        positions_todo.push_back({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
        positions_todo.push_back({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
        positions_todo.push_back({32'h0, 32'h0, 32'h0});
        positions_todo.push_back({32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});

        // Random phases; the first keeps the extreme setting above.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph > 0)
            begin
                rad = $urandom() >> $urandom_range(1, 31);
                load_sphere($urandom(), $urandom(), $urandom(),
                            (ph == 7) ? 32'h7FFF_FFFF : rad,
                            $urandom() >> $urandom_range(0, 31));
            end
            no_gaps = (ph % 3 == 1);
            for (int k = 0; k < 225; k++)
            begin
                positions_todo.push_back(random_position());
                if (ph == 2 && k == 20)
                begin
                    // receiver stops for a long stretch while positions keep coming
                    long_hold_tgl = ~long_hold_tgl;
                    no_gaps = 1'b1;
                end
                if (ph == 4 && k == 100)
                    drain();   // sender waits for every result mid-phase
                while (positions_todo.size() > 40)
                    @(negedge clk);
            end
        end

        drain();
        repeat (LAT + 20) @(negedge clk);
        if (fail_cnt == 0 && forces_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
